@@ rtl/core/mvmd_pkg.sv @@
`default_nettype none

package mvmd_pkg;

  // Default volume limits, handed to the top level parameters.
  localparam int unsigned MAX_X_DEF = 256;
  localparam int unsigned MAX_Y_DEF = 256;
  localparam int unsigned MAX_Z_DEF = 1024;

  // Field and register widths.
  localparam int unsigned SIZE_X_W   = 9;
  localparam int unsigned SIZE_Y_W   = 9;
  localparam int unsigned SIZE_Z_W   = 11;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned VALUE_W    = 8;
  localparam int unsigned OUT_X_W    = 7;
  localparam int unsigned OUT_Y_W    = 7;
  localparam int unsigned OUT_Z_W    = 9;

  // Size register values after reset.
  localparam int unsigned SIZE_X_RST = 256;
  localparam int unsigned SIZE_Y_RST = 256;
  localparam int unsigned SIZE_Z_RST = 256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIZE_X = 2'd0,
    CFG_SIZE_Y = 2'd1,
    CFG_SIZE_Z = 2'd2
  } cfg_index_e;

  typedef logic [VALUE_W-1:0] value_t;

  // One voxel as it leaves the scan stage for the merge stage.
  typedef struct packed {
    logic                 touch;   // closes an x pair, so the plane entry is updated
    logic                 merge;   // combines with the stored partial maximum
    logic                 emit;    // closes the whole block
    logic                 eov;     // last block of the volume
    value_t               pair;
    logic [OUT_X_W-1:0]   ox;
    logic [OUT_Y_W-1:0]   oy;
    logic [OUT_Z_W-1:0]   oz;
  } scan_item_t;

  function automatic value_t max_value(value_t a, value_t b);
    return (a > b) ? a : b;
  endfunction

  // Index of the last voxel along an axis: zero acts as one, large values clip.
  function automatic int unsigned last_index(int unsigned raw, int unsigned limit);
    if (raw == 0) begin
      return 0;
    end
    if (raw > limit) begin
      return limit - 1;
    end
    return raw - 1;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/mvmd_ram.sv @@
`default_nettype none

module mvmd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16384
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                         wdata_i,
  input  wire logic                                     re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // A read of the entry being written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/core/mvmd_scan.sv @@
`default_nettype none

module mvmd_scan #(
  parameter int unsigned MAX_X = mvmd_pkg::MAX_X_DEF,
  parameter int unsigned MAX_Y = mvmd_pkg::MAX_Y_DEF,
  parameter int unsigned MAX_Z = mvmd_pkg::MAX_Z_DEF,
  localparam int unsigned PLANE_W = (MAX_X + 1) / 2,
  localparam int unsigned PLANE_H = (MAX_Y + 1) / 2,
  localparam int unsigned DEPTH   = PLANE_W * PLANE_H,
  localparam int unsigned AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  input  wire logic [mvmd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [mvmd_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  wire logic                              accept_i,
  input  wire mvmd_pkg::value_t                  voxel_value_i,
  output mvmd_pkg::scan_item_t                   item_o,
  output logic [AW-1:0]                          addr_o
);

  localparam int unsigned XW = $clog2(MAX_X);
  localparam int unsigned YW = $clog2(MAX_Y);
  localparam int unsigned ZW = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;

  localparam logic [XW-1:0] LAST_X_RST = XW'(mvmd_pkg::last_index(mvmd_pkg::SIZE_X_RST, MAX_X));
  localparam logic [YW-1:0] LAST_Y_RST = YW'(mvmd_pkg::last_index(mvmd_pkg::SIZE_Y_RST, MAX_Y));
  localparam logic [ZW-1:0] LAST_Z_RST = ZW'(mvmd_pkg::last_index(mvmd_pkg::SIZE_Z_RST, MAX_Z));

  logic [XW-1:0] last_x_q, last_x_d;
  logic [YW-1:0] last_y_q, last_y_d;
  logic [ZW-1:0] last_z_q, last_z_d;
  logic [XW-1:0] pos_x_q, pos_x_d;
  logic [YW-1:0] pos_y_q, pos_y_d;
  logic [ZW-1:0] pos_z_q, pos_z_d;
  mvmd_pkg::value_t pair_q, pair_d;

  logic at_last_x, at_last_y, at_last_z;
  logic restart;
  mvmd_pkg::value_t pair_new;

  assign at_last_x = (pos_x_q == last_x_q);
  assign at_last_y = (pos_y_q == last_y_q);
  assign at_last_z = (pos_z_q == last_z_q);

  assign pair_new = pos_x_q[0] ? mvmd_pkg::max_value(pair_q, voxel_value_i) : voxel_value_i;

  always_comb begin
    item_o.touch = pos_x_q[0] | at_last_x;
    item_o.merge = pos_y_q[0] | pos_z_q[0];
    item_o.emit  = (pos_x_q[0] | at_last_x) & (pos_y_q[0] | at_last_y) &
                   (pos_z_q[0] | at_last_z);
    item_o.eov   = at_last_x & at_last_y & at_last_z;
    item_o.pair  = pair_new;
    item_o.ox    = mvmd_pkg::OUT_X_W'(pos_x_q >> 1);
    item_o.oy    = mvmd_pkg::OUT_Y_W'(pos_y_q >> 1);
    item_o.oz    = mvmd_pkg::OUT_Z_W'(pos_z_q >> 1);
  end

  assign addr_o = AW'((32'(pos_y_q) >> 1) * PLANE_W + (32'(pos_x_q) >> 1));

  // Configuration: any write to a size register restarts the volume.
  always_comb begin
    last_x_d = last_x_q;
    last_y_d = last_y_q;
    last_z_d = last_z_q;
    restart  = 1'b0;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        mvmd_pkg::CFG_SIZE_X: begin
          last_x_d = XW'(mvmd_pkg::last_index(32'(cfg_wdata_i[mvmd_pkg::SIZE_X_W-1:0]), MAX_X));
          restart  = 1'b1;
        end
        mvmd_pkg::CFG_SIZE_Y: begin
          last_y_d = YW'(mvmd_pkg::last_index(32'(cfg_wdata_i[mvmd_pkg::SIZE_Y_W-1:0]), MAX_Y));
          restart  = 1'b1;
        end
        mvmd_pkg::CFG_SIZE_Z: begin
          last_z_d = ZW'(mvmd_pkg::last_index(32'(cfg_wdata_i[mvmd_pkg::SIZE_Z_W-1:0]), MAX_Z));
          restart  = 1'b1;
        end
        default: begin
          restart = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    pos_x_d = pos_x_q;
    pos_y_d = pos_y_q;
    pos_z_d = pos_z_q;
    pair_d  = pair_q;
    if (restart) begin
      pos_x_d = '0;
      pos_y_d = '0;
      pos_z_d = '0;
      pair_d  = '0;
    end else if (accept_i) begin
      pair_d = pair_new;
      if (at_last_x) begin
        pos_x_d = '0;
        if (at_last_y) begin
          pos_y_d = '0;
          pos_z_d = at_last_z ? '0 : pos_z_q + 1'b1;
        end else begin
          pos_y_d = pos_y_q + 1'b1;
        end
      end else begin
        pos_x_d = pos_x_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_x_q <= LAST_X_RST;
      last_y_q <= LAST_Y_RST;
      last_z_q <= LAST_Z_RST;
      pos_x_q  <= '0;
      pos_y_q  <= '0;
      pos_z_q  <= '0;
      pair_q   <= '0;
    end else begin
      last_x_q <= last_x_d;
      last_y_q <= last_y_d;
      last_z_q <= last_z_d;
      pos_x_q  <= pos_x_d;
      pos_y_q  <= pos_y_d;
      pos_z_q  <= pos_z_d;
      pair_q   <= pair_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/mask_volume_max_downsample_unit.sv @@
`default_nettype none

// 2x2x2 max pooling of an 8-bit mask volume streamed in raster order (x fastest, then y,
// then z). The unit takes one voxel per cycle while input ready is high; a pooled result
// passes the merge stage register and then an output register after the voxel that
// closes its block is accepted, and input ready drops only while a closing voxel waits
// behind an output request that is not taken. Partial block maxima for one output plane
// live in a single synchronous RAM of ceil(MAX_X/2) * ceil(MAX_Y/2) bytes, read when a
// voxel is accepted and written back from the merge stage, with the written value
// forwarded to a voxel that reads the same entry at once. Writing any size register
// restarts the volume at its first voxel; zero sizes act as one, sizes over limits clip.
module mask_volume_max_downsample_unit #(
  parameter int unsigned MAX_X = mvmd_pkg::MAX_X_DEF,
  parameter int unsigned MAX_Y = mvmd_pkg::MAX_Y_DEF,
  parameter int unsigned MAX_Z = mvmd_pkg::MAX_Z_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [mvmd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [mvmd_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [mvmd_pkg::VALUE_W-1:0]      voxel_value_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [mvmd_pkg::VALUE_W-1:0]           pooled_value_o,
  output logic [mvmd_pkg::OUT_X_W-1:0]           out_x_o,
  output logic [mvmd_pkg::OUT_Y_W-1:0]           out_y_o,
  output logic [mvmd_pkg::OUT_Z_W-1:0]           out_z_o,
  output logic                                   end_of_volume_o
);

  localparam int unsigned DEPTH = ((MAX_X + 1) / 2) * ((MAX_Y + 1) / 2);
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  mvmd_pkg::scan_item_t scan_item;
  logic [AW-1:0]        scan_addr;
  logic                 accept;
  logic                 stall;
  logic                 advance;

  mvmd_pkg::scan_item_t s1_item_q;
  logic [AW-1:0]        s1_addr_q;
  logic                 s1_valid_q;
  logic                 s1_fwd_q;
  mvmd_pkg::value_t     s1_fwd_data_q;
  mvmd_pkg::value_t     ram_rdata;
  mvmd_pkg::value_t     stored;
  mvmd_pkg::value_t     s1_acc;
  logic                 s1_wr;

  logic                              out_valid_q;
  mvmd_pkg::value_t                  out_value_q;
  logic [mvmd_pkg::OUT_X_W-1:0]      out_x_q;
  logic [mvmd_pkg::OUT_Y_W-1:0]      out_y_q;
  logic [mvmd_pkg::OUT_Z_W-1:0]      out_z_q;
  logic                              out_eov_q;

  // The merge stage holds only when it must emit and the output request is still pending.
  assign stall   = s1_valid_q & s1_item_q.emit & out_valid_q & ~out_ready_i;
  assign advance = ~stall;
  assign in_ready_o  = advance;
  assign accept      = in_valid_i & in_ready_o;
  assign cfg_ready_o = 1'b1;

  mvmd_scan #(
    .MAX_X (MAX_X),
    .MAX_Y (MAX_Y),
    .MAX_Z (MAX_Z)
  ) u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .accept_i      (accept),
    .voxel_value_i (voxel_value_i),
    .item_o        (scan_item),
    .addr_o        (scan_addr)
  );

  assign s1_wr  = s1_valid_q & s1_item_q.touch & advance;
  assign stored = s1_fwd_q ? s1_fwd_data_q : ram_rdata;
  assign s1_acc = s1_item_q.merge ? mvmd_pkg::max_value(s1_item_q.pair, stored)
                                  : s1_item_q.pair;

  mvmd_ram #(
    .WIDTH (mvmd_pkg::VALUE_W),
    .DEPTH (DEPTH)
  ) u_plane_ram (
    .clk_i   (clk_i),
    .we_i    (s1_wr),
    .waddr_i (s1_addr_q),
    .wdata_i (s1_acc),
    .re_i    (accept),
    .raddr_i (scan_addr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= accept;
    end
  end

  // The RAM returns old data when a voxel reads the entry written back in the same cycle,
  // so that value is captured here instead.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q     <= scan_item;
      s1_addr_q     <= scan_addr;
      s1_fwd_q      <= s1_wr & (s1_addr_q == scan_addr);
      s1_fwd_data_q <= s1_acc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_valid_q & s1_item_q.emit & advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q & s1_item_q.emit & advance) begin
      out_value_q <= s1_acc;
      out_x_q     <= s1_item_q.ox;
      out_y_q     <= s1_item_q.oy;
      out_z_q     <= s1_item_q.oz;
      out_eov_q   <= s1_item_q.eov;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pooled_value_o  = out_value_q;
  assign out_x_o         = out_x_q;
  assign out_y_o         = out_y_q;
  assign out_z_o         = out_z_q;
  assign end_of_volume_o = out_eov_q;

endmodule

`default_nettype wire

@@ rtl/core/mvmd_checker.sv @@
`default_nettype none

module mvmd_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              in_valid_i,
  input wire logic                              in_ready_o,
  input wire logic                              out_valid_o,
  input wire logic                              out_ready_i,
  input wire logic [mvmd_pkg::VALUE_W-1:0]      pooled_value_o,
  input wire logic [mvmd_pkg::OUT_X_W-1:0]      out_x_o,
  input wire logic [mvmd_pkg::OUT_Y_W-1:0]      out_y_o,
  input wire logic [mvmd_pkg::OUT_Z_W-1:0]      out_z_o,
  input wire logic                              end_of_volume_o
);

  // A pending output request holds its payload until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pooled_value_o) &&
      $stable(out_x_o) && $stable(out_y_o) && $stable(out_z_o) && $stable(end_of_volume_o))
  else $error("output request changed before it was taken");

  // Input is refused only while the output register is full and not draining.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o || out_ready_i |-> in_ready_o)
  else $error("input stalled with room at the output");

  // A new result request only follows an accepted voxel that passed the merge stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
  else $error("result without a closing voxel");

endmodule

bind mask_volume_max_downsample_unit mvmd_checker u_mvmd_checker (.*);

`default_nettype wire

@@ tb/mask_volume_max_downsample_unit_test.sv @@
`timescale 1ns / 1ps

module mask_volume_max_downsample_unit_test;

  localparam int unsigned MAX_X = mvmd_pkg::MAX_X_DEF;
  localparam int unsigned MAX_Y = mvmd_pkg::MAX_Y_DEF;
  localparam int unsigned MAX_Z = mvmd_pkg::MAX_Z_DEF;
  localparam int unsigned SIZE_X_W = mvmd_pkg::SIZE_X_W;
  localparam int unsigned SIZE_Y_W = mvmd_pkg::SIZE_Y_W;
  localparam int unsigned SIZE_Z_W = mvmd_pkg::SIZE_Z_W;
  localparam int unsigned CFG_IDX_W = mvmd_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DATA_W = mvmd_pkg::CFG_DATA_W;
  localparam int unsigned OUT_X_W = mvmd_pkg::OUT_X_W;
  localparam int unsigned OUT_Y_W = mvmd_pkg::OUT_Y_W;
  localparam int unsigned OUT_Z_W = mvmd_pkg::OUT_Z_W;
  localparam int unsigned PLANE_W = (MAX_X + 1) / 2;
  localparam int unsigned PLANE_H = (MAX_Y + 1) / 2;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned RANDOM_VOXELS = 130;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    mvmd_pkg::value_t   value;
    logic [OUT_X_W-1:0] ox;
    logic [OUT_Y_W-1:0] oy;
    logic [OUT_Z_W-1:0] oz;
    logic               eov;
  } pooled_block_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  mvmd_pkg::value_t      voxel = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  mvmd_pkg::value_t      pooled_value;
  logic [OUT_X_W-1:0]    out_x;
  logic [OUT_Y_W-1:0]    out_y;
  logic [OUT_Z_W-1:0]    out_z;
  logic                  end_of_volume;

  // Predictor state: sizes as written, scan position and partial maxima.
  logic [SIZE_X_W-1:0] size_x_reg = SIZE_X_W'(mvmd_pkg::SIZE_X_RST);
  logic [SIZE_Y_W-1:0] size_y_reg = SIZE_Y_W'(mvmd_pkg::SIZE_Y_RST);
  logic [SIZE_Z_W-1:0] size_z_reg = SIZE_Z_W'(mvmd_pkg::SIZE_Z_RST);
  mvmd_pkg::value_t    plane_max [PLANE_W * PLANE_H];
  mvmd_pkg::value_t    pair_max = '0;
  int unsigned         scan_x = 0;
  int unsigned         scan_y = 0;
  int unsigned         scan_z = 0;

  pooled_block_t pending_blocks [$];
  int unsigned   voxels_sent = 0;
  int unsigned   blocks_checked = 0;
  int unsigned   cfg_writes = 0;
  int unsigned   mismatches = 0;
  int unsigned   feed_quiet = 0;

  mask_volume_max_downsample_unit u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .voxel_value_i   (voxel),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .pooled_value_o  (pooled_value),
    .out_x_o         (out_x),
    .out_y_o         (out_y),
    .out_z_o         (out_z),
    .end_of_volume_o (end_of_volume)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned active_extent(int unsigned raw, int unsigned limit);
    if (raw == 0) begin
      return 1;
    end
    return (raw > limit) ? limit : raw;
  endfunction

  function automatic int unsigned volume_span();
    return active_extent(size_x_reg, MAX_X) * active_extent(size_y_reg, MAX_Y) *
           active_extent(size_z_reg, MAX_Z);
  endfunction

  // Either side may idle between requests, with occasional runs of no idling at all.
  function automatic int unsigned draw_wait(inout int unsigned quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      quiet_left = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  function automatic mvmd_pkg::value_t pick_value();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return mvmd_pkg::value_t'(1);
      default: return mvmd_pkg::value_t'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] data);
    case (idx)
      mvmd_pkg::CFG_SIZE_X: size_x_reg = data[SIZE_X_W-1:0];
      mvmd_pkg::CFG_SIZE_Y: size_y_reg = data[SIZE_Y_W-1:0];
      mvmd_pkg::CFG_SIZE_Z: size_z_reg = data[SIZE_Z_W-1:0];
      default: return;
    endcase
    pair_max = '0;
    scan_x = 0;
    scan_y = 0;
    scan_z = 0;
  endfunction

  function automatic void accumulate_voxel(mvmd_pkg::value_t v);
    int unsigned      ex;
    int unsigned      ey;
    int unsigned      ez;
    int unsigned      x;
    int unsigned      y;
    int unsigned      z;
    int unsigned      slot;
    bit               end_x;
    bit               end_y;
    bit               end_z;
    mvmd_pkg::value_t acc;
    pooled_block_t    blk;
    ex = active_extent(size_x_reg, MAX_X);
    ey = active_extent(size_y_reg, MAX_Y);
    ez = active_extent(size_z_reg, MAX_Z);
    x = (scan_x >= ex) ? ex - 1 : scan_x;
    y = (scan_y >= ey) ? ey - 1 : scan_y;
    z = (scan_z >= ez) ? ez - 1 : scan_z;
    end_x = (x == ex - 1);
    end_y = (y == ey - 1);
    end_z = (z == ez - 1);
    if (x % 2 == 1) begin
      pair_max = (v > pair_max) ? v : pair_max;
    end else begin
      pair_max = v;
    end
    // A closed x pair folds into the plane entry; the odd row or slice also merges.
    if (x % 2 == 1 || end_x) begin
      slot = (y / 2) * PLANE_W + x / 2;
      acc = pair_max;
      if (y % 2 == 1 || z % 2 == 1) begin
        acc = (plane_max[slot] > acc) ? plane_max[slot] : acc;
      end
      plane_max[slot] = acc;
      if ((y % 2 == 1 || end_y) && (z % 2 == 1 || end_z)) begin
        blk.value = acc;
        blk.ox = OUT_X_W'(x / 2);
        blk.oy = OUT_Y_W'(y / 2);
        blk.oz = OUT_Z_W'(z / 2);
        blk.eov = end_x && end_y && end_z;
        pending_blocks.insert(pending_blocks.size(), blk);
      end
    end
    if (end_x) begin
      x = 0;
      if (end_y) begin
        y = 0;
        z = end_z ? 0 : z + 1;
      end else begin
        y++;
      end
    end else begin
      x++;
    end
    scan_x = x;
    scan_y = y;
    scan_z = z;
  endfunction

  // Valid is only lowered when a gap follows, so back-to-back requests keep it high.
  task automatic send_voxel(input mvmd_pkg::value_t v);
    int unsigned hold;
    hold = draw_wait(feed_quiet);
    if (hold > 0) begin
      in_valid <= 1'b0;
      repeat (hold) @(posedge clk);
    end
    in_valid <= 1'b1;
    voxel <= v;
    do @(posedge clk); while (!in_ready);
    accumulate_voxel(v);
    voxels_sent++;
  endtask

  task automatic send_stream(input int unsigned count);
    repeat (count) send_voxel(pick_value());
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    repeat ($urandom_range(1, 4)) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_register(idx, data);
    cfg_writes++;
  endtask

  // Voxels that close no block may still be in the pipeline once the queue drains.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_sizes(input int unsigned sx, input int unsigned sy, input int unsigned sz);
    settle();
    cfg_write(mvmd_pkg::CFG_SIZE_X, CFG_DATA_W'(sx));
    cfg_write(mvmd_pkg::CFG_SIZE_Y, CFG_DATA_W'(sy));
    cfg_write(mvmd_pkg::CFG_SIZE_Z, CFG_DATA_W'(sz));
  endtask

  // The width stays at its reset value of 256 throughout this test.
  task automatic test_reset_sizes();
    cfg_write(mvmd_pkg::CFG_SIZE_Y, CFG_DATA_W'(1));
    cfg_write(mvmd_pkg::CFG_SIZE_Z, CFG_DATA_W'(1));
    send_stream(volume_span());
  endtask

  task automatic test_edge_cases();
    mvmd_pkg::value_t corner_vals [8];
    corner_vals = '{8'd0, 8'd128, 8'd7, 8'd255, 8'd3, 8'd0, 8'd254, 8'd1};
    set_sizes(2, 2, 2);
    foreach (corner_vals[i]) send_voxel(corner_vals[i]);
    set_sizes(3, 1, 3);
    send_stream(9);
    set_sizes(1, 3, 1);
    send_voxel('0);
    send_voxel('1);
    send_voxel('0);
    // Sizes of zero behave as a single voxel.
    set_sizes(0, 0, 0);
    send_voxel('1);
  endtask

  task automatic test_volume_wrap();
    set_sizes(3, 2, 3);
    send_stream(2 * volume_span());
  endtask

  task automatic test_restart_on_write();
    set_sizes(3, 3, 2);
    send_stream(10);
    settle();
    cfg_write(mvmd_pkg::CFG_SIZE_Y, CFG_DATA_W'(3));
    send_stream(volume_span());
  endtask

  task automatic test_spare_register();
    set_sizes(4, 2, 2);
    send_stream(6);
    settle();
    cfg_write(CFG_SPARE, '1);
    send_stream(10);
  endtask

  task automatic test_random_volumes();
    int unsigned           start;
    int unsigned           span;
    bit                    wrote;
    logic [CFG_DATA_W-1:0] data;
    start = voxels_sent;
    while (voxels_sent - start < RANDOM_VOXELS) begin
      settle();
      wrote = 1'b0;
      if ($urandom_range(0, 3) == 0) begin
        cfg_write(CFG_SPARE, CFG_DATA_W'($urandom_range(0, 2047)));
      end
      if ($urandom_range(0, 2) != 0) begin
        data = CFG_DATA_W'($urandom_range(1, 5));
        case ($urandom_range(0, 9))
          0: data = '0;
          1: data[CFG_DATA_W-1:SIZE_X_W] = 2'($urandom_range(1, 3));
          default: ;
        endcase
        cfg_write(mvmd_pkg::CFG_SIZE_X, data);
        wrote = 1'b1;
      end
      if ($urandom_range(0, 2) != 0) begin
        data = CFG_DATA_W'($urandom_range(1, 5));
        case ($urandom_range(0, 9))
          0: data = '0;
          1: data[CFG_DATA_W-1:SIZE_Y_W] = 2'($urandom_range(1, 3));
          default: ;
        endcase
        cfg_write(mvmd_pkg::CFG_SIZE_Y, data);
        wrote = 1'b1;
      end
      if (!wrote || $urandom_range(0, 2) != 0) begin
        data = ($urandom_range(0, 9) == 0) ? '0 : CFG_DATA_W'($urandom_range(1, 3));
        cfg_write(mvmd_pkg::CFG_SIZE_Z, data);
      end
      span = volume_span();
      // Mostly whole volumes, sometimes cut short before the next write restarts it.
      if ($urandom_range(0, 5) == 0) begin
        send_stream($urandom_range(1, span));
      end else begin
        send_stream(span * $urandom_range(1, 2));
      end
    end
  endtask

  initial begin : collect_results
    int unsigned   hold;
    int unsigned   drain_quiet;
    pooled_block_t got;
    pooled_block_t want;
    drain_quiet = 0;
    wait (rst_n === 1'b1);
    forever begin
      hold = draw_wait(drain_quiet);
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got = '{pooled_value, out_x, out_y, out_z, end_of_volume};
      if (pending_blocks.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("Unexpected block: value %0d at (%0d,%0d,%0d) end %0b", got.value,
                   got.ox, got.oy, got.oz, got.eov);
        end
      end else begin
        want = pending_blocks.pop_front();
        blocks_checked++;
        if (got.value !== want.value || got.ox !== want.ox || got.oy !== want.oy ||
            got.oz !== want.oz || got.eov !== want.eov) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("Block %0d: expected value %0d at (%0d,%0d,%0d) end %0b,",
                     blocks_checked, want.value, want.ox, want.oy, want.oz, want.eov);
            $display("  got value %0d at (%0d,%0d,%0d) end %0b",
                     got.value, got.ox, got.oy, got.oz, got.eov);
          end
        end
      end
    end
  end

  initial begin : stall_watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Timeout: no request accepted for %0d cycles", STALL_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_sizes();
    test_edge_cases();
    test_volume_wrap();
    test_restart_on_write();
    test_spare_register();
    test_random_volumes();
    settle();
    $display("Streamed %0d voxels through %0d register writes, including the reset width,",
             voxels_sent, cfg_writes);
    $display("odd edges, zero sizes and volume wrap; %0d pooled blocks compared.",
             blocks_checked);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/mvmd_pkg.sv
rtl/core/mvmd_ram.sv
rtl/core/mvmd_scan.sv
rtl/core/mask_volume_max_downsample_unit.sv
rtl/core/mvmd_checker.sv
tb/mask_volume_max_downsample_unit_test.sv
